>>> rtl/core/gr6_pkg.sv
`timescale 1ns / 1ps

package gr6_pkg;

    localparam logic [7:0] BYTE_LF     = 8'd10;
    localparam logic [7:0] BYTE_CR     = 8'd13;
    localparam logic [7:0] BYTE_BIAS   = 8'd63;
    localparam logic [7:0] BYTE_LONG   = 8'd126;
    localparam logic [3:0] PREFIX_LEN  = 4'd10;
    localparam logic [2:0] BITS_PER_CH = 3'd6;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_INVALID = 3'd2,
        ST_LENGTH  = 3'd3,
        ST_PADDING = 3'd4
    } t_status;

    typedef enum logic {
        KIND_EDGE = 1'b0,
        KIND_END  = 1'b1
    } t_kind;

    // One queue entry: either a block of adjacency bits or the end of a record.
    typedef struct packed {
        logic       is_end;
        logic [5:0] word;
        logic [2:0] nbits;
        logic [5:0] vcount;
        t_status    status;
    } t_cmd;

    // Characters of the optional ">>graph6<<" record prefix.
    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'd62;
            4'd1:    c = 8'd62;
            4'd2:    c = 8'd103;
            4'd3:    c = 8'd114;
            4'd4:    c = 8'd97;
            4'd5:    c = 8'd112;
            4'd6:    c = 8'd104;
            4'd7:    c = 8'd54;
            4'd8:    c = 8'd60;
            4'd9:    c = 8'd60;
            default: c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/gr6_front.sv
`timescale 1ns / 1ps

module gr6_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_in_byte,
    input  logic             i_full,
    output logic             o_push,
    output gr6_pkg::t_cmd    o_cmd
);

    logic [3:0]       r_pp,      n_pp;
    logic             r_cr,      n_cr;
    logic             r_ord,     n_ord;
    logic [5:0]       r_n,       n_n;
    logic [10:0]      r_bits,    n_bits;
    logic             r_extra,   n_extra;
    logic             r_pad_bad, n_pad_bad;
    gr6_pkg::t_status r_err,     n_err;

    logic             accept;
    logic             byte_ok;
    logic [7:0]       byte_off;
    logic [5:0]       word;
    logic [11:0]      pairs;
    logic [2:0]       nb;
    gr6_pkg::t_status err_v;
    gr6_pkg::t_status end_st;

    assign accept   = i_valid & ~i_full;
    assign byte_ok  = i_in_byte inside {[8'd63:8'd126]};
    assign byte_off = i_in_byte - gr6_pkg::BYTE_BIAS;
    assign word     = byte_off[5:0];
    assign pairs    = {6'd0, word} * {6'd0, word - 6'd1};
    assign nb       = (r_bits >= 11'(gr6_pkg::BITS_PER_CH)) ? gr6_pkg::BITS_PER_CH
                                                             : r_bits[2:0];

    always_comb begin
        if (r_err != gr6_pkg::ST_OK) begin
            end_st = r_err;
        end else if (r_pp != 4'd0 && r_pp != gr6_pkg::PREFIX_LEN) begin
            end_st = gr6_pkg::ST_INVALID;
        end else if (!r_ord) begin
            end_st = gr6_pkg::ST_EMPTY;
        end else if (r_bits != 11'd0 || r_extra) begin
            end_st = gr6_pkg::ST_LENGTH;
        end else if (r_pad_bad) begin
            end_st = gr6_pkg::ST_PADDING;
        end else begin
            end_st = gr6_pkg::ST_OK;
        end
    end

    always_comb begin
        n_pp      = r_pp;
        n_cr      = r_cr;
        n_ord     = r_ord;
        n_n       = r_n;
        n_bits    = r_bits;
        n_extra   = r_extra;
        n_pad_bad = r_pad_bad;
        n_err     = r_err;
        err_v     = r_err;
        o_push    = 1'b0;
        o_cmd     = '0;
        if (accept) begin
            if (i_in_byte == gr6_pkg::BYTE_LF) begin
                o_push       = 1'b1;
                o_cmd.is_end = 1'b1;
                o_cmd.vcount = r_ord ? r_n : 6'd0;
                o_cmd.status = end_st;
                n_pp         = 4'd0;
                n_cr         = 1'b0;
                n_ord        = 1'b0;
                n_n          = 6'd0;
                n_bits       = 11'd0;
                n_extra      = 1'b0;
                n_pad_bad    = 1'b0;
                n_err        = gr6_pkg::ST_OK;
            end else begin
                // A held carriage return that is not followed by the newline is a bad byte.
                if (r_cr && err_v == gr6_pkg::ST_OK) begin
                    err_v = gr6_pkg::ST_INVALID;
                end
                n_cr = 1'b0;
                if (i_in_byte == gr6_pkg::BYTE_CR) begin
                    n_cr = 1'b1;
                end else if (err_v == gr6_pkg::ST_OK) begin
                    if (!r_ord) begin
                        if (r_pp != gr6_pkg::PREFIX_LEN
                            && i_in_byte == gr6_pkg::prefix_char(r_pp)) begin
                            n_pp = r_pp + 4'd1;
                        end else if (r_pp != 4'd0 && r_pp != gr6_pkg::PREFIX_LEN) begin
                            err_v = gr6_pkg::ST_INVALID;
                        end else if (i_in_byte == gr6_pkg::BYTE_LONG) begin
                            err_v = gr6_pkg::ST_EMPTY;
                        end else if (!byte_ok) begin
                            err_v = gr6_pkg::ST_INVALID;
                        end else begin
                            n_n    = word;
                            n_ord  = 1'b1;
                            n_bits = pairs[11:1];
                        end
                    end else if (!byte_ok) begin
                        err_v = gr6_pkg::ST_INVALID;
                    end else if (r_bits == 11'd0) begin
                        n_extra = 1'b1;
                    end else begin
                        o_push      = 1'b1;
                        o_cmd.word  = word & ~(6'h3F >> nb);
                        o_cmd.nbits = nb;
                        n_bits      = r_bits - 11'(nb);
                        n_pad_bad   = |(word & (6'h3F >> nb));
                    end
                end
                n_err = err_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp      <= 4'd0;
            r_cr      <= 1'b0;
            r_ord     <= 1'b0;
            r_n       <= 6'd0;
            r_bits    <= 11'd0;
            r_extra   <= 1'b0;
            r_pad_bad <= 1'b0;
            r_err     <= gr6_pkg::ST_OK;
        end else begin
            r_pp      <= n_pp;
            r_cr      <= n_cr;
            r_ord     <= n_ord;
            r_n       <= n_n;
            r_bits    <= n_bits;
            r_extra   <= n_extra;
            r_pad_bad <= n_pad_bad;
            r_err     <= n_err;
        end
    end

endmodule

>>> rtl/core/gr6_queue.sv
`timescale 1ns / 1ps

module gr6_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gr6_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output gr6_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    gr6_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr,  n_wr;
    logic [AW-1:0] r_rd,  n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> rtl/core/gr6_back.sv
`timescale 1ns / 1ps

module gr6_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gr6_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    input  logic          i_stall,
    output logic          o_valid,
    output logic          o_kind,
    output logic [5:0]    o_lower_vertex,
    output logic [5:0]    o_upper_vertex,
    output logic [5:0]    o_vertex_count,
    output logic [2:0]    o_status,
    output logic          o_run_last
);

    logic       r_busy,  n_busy;
    logic [5:0] r_word,  n_word;
    logic [2:0] r_nleft, n_nleft;
    logic [5:0] r_row,   n_row;
    logic [5:0] r_col,   n_col;
    logic       r_ovalid, n_ovalid;
    logic       r_kind,  n_kind;
    logic [5:0] r_lo,    n_lo;
    logic [5:0] r_hi,    n_hi;
    logic [5:0] r_vc,    n_vc;
    logic [2:0] r_st,    n_st;
    logic       r_last,  n_last;

    logic       out_ready;
    logic       step;
    logic       finish;
    logic       take_end;
    logic       take_data;
    logic       emit_edge;
    logic [5:0] row_inc;

    assign out_ready = ~r_ovalid | ~i_stall;
    assign step      = r_busy & out_ready;
    assign finish    = step & (r_nleft == 3'd1);
    assign take_end  = ~i_empty & i_cmd.is_end & ~r_busy & out_ready;
    assign take_data = ~i_empty & ~i_cmd.is_end & (~r_busy | finish);
    assign o_pop     = take_end | take_data;
    assign emit_edge = step & r_word[5];
    assign row_inc   = r_row + 6'd1;

    always_comb begin
        n_busy  = r_busy;
        n_word  = r_word;
        n_nleft = r_nleft;
        n_row   = r_row;
        n_col   = r_col;
        if (step) begin
            n_word  = {r_word[4:0], 1'b0};
            n_nleft = r_nleft - 3'd1;
            n_busy  = ~finish;
            // Bits walk the upper triangle column by column.
            if (row_inc >= r_col) begin
                n_row = 6'd0;
                n_col = r_col + 6'd1;
            end else begin
                n_row = row_inc;
            end
        end
        if (take_data) begin
            n_busy  = 1'b1;
            n_word  = i_cmd.word;
            n_nleft = i_cmd.nbits;
        end
        if (take_end) begin
            n_row = 6'd0;
            n_col = 6'd1;
        end
    end

    always_comb begin
        n_ovalid = r_ovalid;
        n_kind   = r_kind;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_vc     = r_vc;
        n_st     = r_st;
        n_last   = r_last;
        if (out_ready) begin
            n_ovalid = emit_edge | take_end;
            if (emit_edge) begin
                n_kind = gr6_pkg::KIND_EDGE;
                n_lo   = r_row;
                n_hi   = r_col;
                n_vc   = 6'd0;
                n_st   = gr6_pkg::ST_OK;
                // Unused bits were cleared on entry, so this is the beat's last edge.
                n_last = ~|r_word[4:0];
            end else if (take_end) begin
                n_kind = gr6_pkg::KIND_END;
                n_lo   = 6'd0;
                n_hi   = 6'd0;
                n_vc   = i_cmd.vcount;
                n_st   = i_cmd.status;
                n_last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_nleft  <= 3'd0;
            r_row    <= 6'd0;
            r_col    <= 6'd1;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_nleft  <= n_nleft;
            r_row    <= n_row;
            r_col    <= n_col;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_kind <= n_kind;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_vc   <= n_vc;
        r_st   <= n_st;
        r_last <= n_last;
    end

    assign o_valid        = r_ovalid;
    assign o_kind         = r_kind;
    assign o_lower_vertex = r_lo;
    assign o_upper_vertex = r_hi;
    assign o_vertex_count = r_vc;
    assign o_status       = r_st;
    assign o_run_last     = r_last;

endmodule

>>> rtl/core/graph6_record_decoder.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake           Payload
// input    in         i_valid / o_stall   i_in_byte
// output   out        o_valid / i_stall   o_kind, o_lower_vertex, o_upper_vertex,
//                                         o_vertex_count, o_status, o_run_last
//
// The front takes one byte per cycle while the queue is not full and queues
// work for the back. The back walks adjacency bits at one bit per cycle while
// the output is not stalled, so a data byte gives it up to six bits (fewer in the
// last byte of a record); a newline gives it an end beat, other bytes nothing.
// Reset is synchronous and active low; all record state and the queue clear at once.
// The input stalls only while the queue is full; the output register holds its beat
// while stalled and the back waits behind it.

module graph6_record_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_kind,
    output logic [5:0] o_lower_vertex,
    output logic [5:0] o_upper_vertex,
    output logic [5:0] o_vertex_count,
    output logic [2:0] o_status,
    output logic       o_run_last
);

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    gr6_pkg::t_cmd push_cmd;
    gr6_pkg::t_cmd head_cmd;

    assign o_stall = full;

    gr6_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_in_byte (i_in_byte),
        .i_full    (full),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    gr6_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    gr6_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (head_cmd),
        .i_empty        (empty),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_lower_vertex (o_lower_vertex),
        .o_upper_vertex (o_upper_vertex),
        .o_vertex_count (o_vertex_count),
        .o_status       (o_status),
        .o_run_last     (o_run_last)
    );

endmodule
